@@ rtl/sbsd_pkg.sv @@
// ============================================================================
// sbsd_pkg
// Shared types, register codes and helpers of the swept box distance unit.
// ============================================================================
package sbsd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Z      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZES = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd7;

    localparam int XFORM_STAGES   = 8;
    localparam int SQRT_ITER      = 34;
    localparam int DIV_ITER       = 17;
    localparam int SQRT_STEPS_DEF = 4;
    localparam int DIV_STEPS_DEF  = 4;

    localparam logic signed [31:0] DIST_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;
    localparam logic signed [17:0] GRAD_MAX = 18'sh1ffff;
    localparam logic signed [17:0] GRAD_MIN = 18'sh20000;

    typedef logic [53:0] t_rot_row;

    typedef struct packed {
        logic       in_box;
        logic       ovf;
        logic [2:0] neg;
    } t_meta;

    typedef struct packed {
        logic signed [31:0] distance;
        logic signed [17:0] gx;
        logic signed [17:0] gy;
        logic signed [17:0] gz;
        logic               in_box;
        logic               degen;
    } t_res;

    function automatic logic signed [17:0] rot_at(input t_rot_row row, input int j);
        return $signed(row[18*j +: 18]);
    endfunction

endpackage

@@ rtl/sbsd_xform.sv @@
// ============================================================================
// sbsd_xform
// Box-space transform, face/clamp select, range scaling and squared length.
// ============================================================================
module sbsd_xform import sbsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_qx,
    input  logic signed [31:0] i_qy,
    input  logic signed [31:0] i_qz,
    input  t_rot_row           i_rot [3],
    input  logic signed [31:0] i_pos [3],
    input  logic [59:0]        i_half,
    input  logic [30:0]        i_radius,
    output t_meta              o_meta,
    output logic [31:0]        o_c [3],
    output logic [65:0]        o_sum
);

    logic signed [31:0] q [3];

    logic signed [32:0] r_d [3], n_d [3];
    logic signed [50:0] r_prd [3][3], n_prd [3][3];
    logic signed [36:0] r3_p [3], n3_p [3];
    logic signed [32:0] r3_box [3], n3_box [3];
    logic signed [36:0] r4_p [3];
    logic signed [32:0] r4_box [3];
    logic [1:0]         r4_side, n4_side;
    logic               r4_inside, n4_inside;
    logic [37:0]        r5_mag [3], n5_mag [3];
    logic [2:0]         r5_neg, n5_neg;
    logic               r5_inside;
    logic [31:0]        r6_c [3], n6_c [3];
    t_meta              r6_meta, n6_meta;
    logic [63:0]        r7_sq [3], n7_sq [3];
    logic [31:0]        r7_c [3];
    t_meta              r7_meta;
    logic [65:0]        r8_sum, n8_sum;
    logic [31:0]        r8_c [3];
    t_meta              r8_meta;

    assign q[0] = i_qx;
    assign q[1] = i_qy;
    assign q[2] = i_qz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i] = 33'(q[i]) - 33'(i_pos[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prd[i][j] = 51'(rot_at(i_rot[i], j)) * 51'(r_d[i]);
            end
        end
    end

    always_comb begin
        logic signed [52:0] acc;
        acc = '0;
        for (int j = 0; j < 3; j++) begin
            acc = 53'(r_prd[0][j]) + 53'(r_prd[1][j]) + 53'(r_prd[2][j]) + 53'sd32768;
            n3_p[j]   = acc[52:16];
            n3_box[j] = $signed({13'd0, i_half[20*j +: 20]}) - $signed({2'd0, i_radius});
        end
    end

    always_comb begin
        logic signed [37:0] pa [3];
        logic signed [38:0] dab [3];
        logic [1:0]         s1;
        for (int j = 0; j < 3; j++) begin
            pa[j]  = r3_p[j][36] ? -38'(r3_p[j]) : 38'(r3_p[j]);
            dab[j] = 39'(pa[j]) - 39'(r3_box[j]);
        end
        s1        = (dab[1] > dab[0]) ? 2'd1 : 2'd0;
        n4_side   = (dab[2] > dab[s1]) ? 2'd2 : s1;
        n4_inside = dab[n4_side][38];
    end

    always_comb begin
        logic signed [37:0] p38, b38, cl;
        logic signed [38:0] del;
        p38 = '0;
        b38 = '0;
        cl  = '0;
        del = '0;
        for (int j = 0; j < 3; j++) begin
            p38 = 38'(r4_p[j]);
            b38 = 38'(r4_box[j]);
            if (r4_inside) begin
                cl = p38;
                if (r4_side == 2'(j)) begin
                    cl = (p38 > 0) ? b38 : -b38;
                end
            end else begin
                cl = (p38 < -b38) ? -b38 : p38;
                if (cl > b38) begin
                    cl = b38;
                end
            end
            del       = 39'(p38) - 39'(cl);
            n5_neg[j] = del[38];
            n5_mag[j] = del[38] ? 38'(-del) : 38'(del);
        end
    end

    always_comb begin
        logic [37:0] m;
        logic [2:0]  sh;
        m = r5_mag[0] | r5_mag[1] | r5_mag[2];
        if (m[37]) begin
            sh = 3'd6;
        end else if (m[36]) begin
            sh = 3'd5;
        end else if (m[35]) begin
            sh = 3'd4;
        end else if (m[34]) begin
            sh = 3'd3;
        end else if (m[33]) begin
            sh = 3'd2;
        end else if (m[32]) begin
            sh = 3'd1;
        end else begin
            sh = 3'd0;
        end
        for (int j = 0; j < 3; j++) begin
            n6_c[j] = 32'(r5_mag[j] >> sh);
        end
        n6_meta.in_box = r5_inside;
        n6_meta.ovf    = (sh != 3'd0);
        n6_meta.neg    = r5_neg;
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n7_sq[j] = 64'(r6_c[j]) * 64'(r6_c[j]);
        end
    end

    assign n8_sum = 66'(r7_sq[0]) + 66'(r7_sq[1]) + 66'(r7_sq[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d       <= n_d;
            r_prd     <= n_prd;
            r3_p      <= n3_p;
            r3_box    <= n3_box;
            r4_p      <= r3_p;
            r4_box    <= r3_box;
            r4_side   <= n4_side;
            r4_inside <= n4_inside;
            r5_mag    <= n5_mag;
            r5_neg    <= n5_neg;
            r5_inside <= r4_inside;
            r6_c      <= n6_c;
            r6_meta   <= n6_meta;
            r7_sq     <= n7_sq;
            r7_c      <= r6_c;
            r7_meta   <= r6_meta;
            r8_sum    <= n8_sum;
            r8_c      <= r7_c;
            r8_meta   <= r7_meta;
        end
    end

    assign o_meta = r8_meta;
    assign o_c    = r8_c;
    assign o_sum  = r8_sum;

endmodule

@@ rtl/sbsd_sqrt.sv @@
// ============================================================================
// sbsd_sqrt
// Pipelined digit-by-digit integer square root of the squared length.
// ============================================================================
module sbsd_sqrt import sbsd_pkg::*; #(
    parameter int STEPS = SQRT_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_meta       i_meta,
    input  logic [31:0] i_c [3],
    input  logic [65:0] i_sum,
    output t_meta       o_meta,
    output logic [31:0] o_c [3],
    output logic [33:0] o_len
);

    localparam int NSTG = (SQRT_ITER + STEPS - 1) / STEPS;

    logic [67:0] r_rad  [NSTG];
    logic [35:0] r_rem  [NSTG];
    logic [33:0] r_res  [NSTG];
    t_meta       r_meta [NSTG];
    logic [31:0] r_c    [NSTG][3];

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic [67:0] rad_in, n_rad;
        logic [35:0] rem_in, n_rem;
        logic [33:0] res_in, n_res;
        t_meta       meta_in;
        logic [31:0] c_in [3];

        if (g == 0) begin : g_head
            assign rad_in  = {2'b00, i_sum};
            assign rem_in  = '0;
            assign res_in  = '0;
            assign meta_in = i_meta;
            assign c_in    = i_c;
        end else begin : g_body
            assign rad_in  = r_rad[g-1];
            assign rem_in  = r_rem[g-1];
            assign res_in  = r_res[g-1];
            assign meta_in = r_meta[g-1];
            assign c_in    = r_c[g-1];
        end

        always_comb begin
            logic [37:0] remx;
            logic [37:0] trial;
            n_rad = rad_in;
            n_rem = rem_in;
            n_res = res_in;
            remx  = '0;
            trial = '0;
            for (int t = 0; t < STEPS; t++) begin
                if (g * STEPS + t < SQRT_ITER) begin
                    remx  = {n_rem, n_rad[67:66]};
                    trial = {2'b00, n_res, 2'b01};
                    n_rad = {n_rad[65:0], 2'b00};
                    if (remx >= trial) begin
                        n_rem = 36'(remx - trial);
                        n_res = {n_res[32:0], 1'b1};
                    end else begin
                        n_rem = 36'(remx);
                        n_res = {n_res[32:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g]  <= n_rad;
                r_rem[g]  <= n_rem;
                r_res[g]  <= n_res;
                r_meta[g] <= meta_in;
                r_c[g]    <= c_in;
            end
        end
    end

    assign o_meta = r_meta[NSTG-1];
    assign o_c    = r_c[NSTG-1];
    assign o_len  = r_res[NSTG-1];

endmodule

@@ rtl/sbsd_div.sv @@
// ============================================================================
// sbsd_div
// Pipelined restoring divider: rounded unit-vector magnitudes, three lanes.
// ============================================================================
module sbsd_div import sbsd_pkg::*; #(
    parameter int STEPS = DIV_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_meta       i_meta,
    input  logic [31:0] i_c [3],
    input  logic [33:0] i_len,
    output t_meta       o_meta,
    output logic [33:0] o_len,
    output logic [16:0] o_q [3]
);

    localparam int NSTG = (DIV_ITER + STEPS - 1) / STEPS;

    logic [33:0] r_rem  [NSTG][3];
    logic [16:0] r_nl   [NSTG][3];
    logic [16:0] r_q    [NSTG][3];
    logic [33:0] r_len  [NSTG];
    t_meta       r_meta [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic [33:0] rem_in [3], n_rem [3];
        logic [16:0] nl_in [3], n_nl [3];
        logic [16:0] q_in [3], n_q [3];
        logic [33:0] len_in;
        t_meta       meta_in;

        if (g == 0) begin : g_head
            always_comb begin
                logic [48:0] num;
                num = '0;
                for (int j = 0; j < 3; j++) begin
                    num       = {1'b0, i_c[j], 16'd0} + 49'(i_len >> 1);
                    rem_in[j] = 34'(num[48:17]);
                    nl_in[j]  = num[16:0];
                    q_in[j]   = '0;
                end
            end
            assign len_in  = i_len;
            assign meta_in = i_meta;
        end else begin : g_body
            assign rem_in  = r_rem[g-1];
            assign nl_in   = r_nl[g-1];
            assign q_in    = r_q[g-1];
            assign len_in  = r_len[g-1];
            assign meta_in = r_meta[g-1];
        end

        always_comb begin
            logic [34:0] rx;
            rx = '0;
            for (int j = 0; j < 3; j++) begin
                n_rem[j] = rem_in[j];
                n_nl[j]  = nl_in[j];
                n_q[j]   = q_in[j];
                for (int t = 0; t < STEPS; t++) begin
                    if (g * STEPS + t < DIV_ITER) begin
                        rx      = {n_rem[j], n_nl[j][16]};
                        n_nl[j] = {n_nl[j][15:0], 1'b0};
                        if (rx >= {1'b0, len_in}) begin
                            n_rem[j] = 34'(rx - {1'b0, len_in});
                            n_q[j]   = {n_q[j][15:0], 1'b1};
                        end else begin
                            n_rem[j] = 34'(rx);
                            n_q[j]   = {n_q[j][15:0], 1'b0};
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_nl[g]   <= n_nl;
                r_q[g]    <= n_q;
                r_len[g]  <= len_in;
                r_meta[g] <= meta_in;
            end
        end
    end

    assign o_meta = r_meta[NSTG-1];
    assign o_len  = r_len[NSTG-1];
    assign o_q    = r_q[NSTG-1];

endmodule

@@ rtl/sbsd_back.sv @@
// ============================================================================
// sbsd_back
// World-space gradient, distance saturation and two-word output queue.
// ============================================================================
module sbsd_back import sbsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic        i_ready,
    input  t_rot_row    i_rot [3],
    input  logic [30:0] i_radius,
    input  t_meta       i_meta,
    input  logic [33:0] i_len,
    input  logic [16:0] i_q [3],
    output logic        o_room,
    output logic        o_valid,
    output t_res        o_res
);

    logic signed [35:0] r_gp [3][3], n_gp [3][3];
    logic signed [31:0] r_dist, n_dist;
    logic               r_inside;
    logic               r_degen;
    t_res               n_res;
    t_res               r_q [2];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt, n_cnt;
    logic               push, pop;

    always_comb begin
        logic signed [17:0] u [3];
        for (int j = 0; j < 3; j++) begin
            u[j] = (i_meta.neg[j] ^ i_meta.in_box) ? -18'(i_q[j]) : 18'(i_q[j]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_gp[i][j] = 36'(rot_at(i_rot[i], j)) * 36'(u[j]);
            end
        end
    end

    always_comb begin
        logic signed [35:0] lens, sv;
        lens = $signed(36'(i_len));
        sv   = (i_meta.in_box ? -lens : lens) - $signed(36'(i_radius));
        if (i_meta.ovf) begin
            n_dist = i_meta.in_box ? DIST_MIN : DIST_MAX;
        end else if (sv > 36'(DIST_MAX)) begin
            n_dist = DIST_MAX;
        end else if (sv < 36'(DIST_MIN)) begin
            n_dist = DIST_MIN;
        end else begin
            n_dist = 32'(sv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gp     <= n_gp;
            r_dist   <= n_dist;
            r_inside <= i_meta.in_box;
            r_degen  <= (i_len == 34'd0);
        end
    end

    always_comb begin
        logic signed [37:0] acc;
        logic signed [21:0] gr;
        logic signed [17:0] g [3];
        acc = '0;
        gr  = '0;
        for (int i = 0; i < 3; i++) begin
            acc = 38'(r_gp[i][0]) + 38'(r_gp[i][1]) + 38'(r_gp[i][2]) + 38'sd32768;
            gr  = acc[37:16];
            if (r_degen) begin
                g[i] = '0;
            end else if (gr > 22'(GRAD_MAX)) begin
                g[i] = GRAD_MAX;
            end else if (gr < 22'(GRAD_MIN)) begin
                g[i] = GRAD_MIN;
            end else begin
                g[i] = 18'(gr);
            end
        end
        n_res.distance = r_dist;
        n_res.gx       = g[0];
        n_res.gy       = g[1];
        n_res.gz       = g[2];
        n_res.in_box   = r_inside;
        n_res.degen    = r_degen;
    end

    assign push  = i_en && i_vld;
    assign pop   = (r_cnt != 2'd0) && i_ready;
    assign n_cnt = r_cnt + 2'(push) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_res;
        end
    end

    assign o_room  = (r_cnt != 2'd2) || i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_q[r_rp];

endmodule

@@ rtl/swept_box_signed_distance_unit.sv @@
// ============================================================================
// swept_box_signed_distance_unit
// Stage chains in order: transform, square root, divider, output stage; the
//   square-root and divider chain lengths follow SQRT_STEPS and DIV_STEPS.
// Throughput: one word per cycle; a two-word output queue absorbs stalls,
//   and while it is full and the result side stalls, the pipeline holds.
// Reset: synchronous active low; clears valid bits, queue and cfg registers.
// ============================================================================
module swept_box_signed_distance_unit import sbsd_pkg::*; #(
    parameter int SQRT_STEPS = SQRT_STEPS_DEF,
    parameter int DIV_STEPS  = DIV_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [31:0]    i_qx,
    input  logic signed [31:0]    i_qy,
    input  logic signed [31:0]    i_qz,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [31:0]    o_distance,
    output logic signed [17:0]    o_grad_x,
    output logic signed [17:0]    o_grad_y,
    output logic signed [17:0]    o_grad_z,
    output logic                  o_is_inside,
    output logic                  o_degenerate
);

    localparam int SQ_STG = (SQRT_ITER + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int DV_STG = (DIV_ITER + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NP     = XFORM_STAGES + SQ_STG + DV_STG + 1;

    t_rot_row           r_rot [3];
    logic signed [31:0] r_pos [3];
    logic [59:0]        r_half;
    logic [30:0]        r_radius;
    logic [NP-1:0]      r_vld;
    logic               en;

    t_meta       x_meta, s_meta, d_meta;
    logic [31:0] x_c [3], s_c [3];
    logic [65:0] x_sum;
    logic [33:0] s_len, d_len;
    logic [16:0] d_q [3];
    t_res        res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= '0;
            r_rot[1] <= '0;
            r_rot[2] <= '0;
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= '0;
            r_half   <= '0;
            r_radius <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROT_ROW0:   r_rot[0] <= i_cfg_data[53:0];
                REG_ROT_ROW1:   r_rot[1] <= i_cfg_data[53:0];
                REG_ROT_ROW2:   r_rot[2] <= i_cfg_data[53:0];
                REG_POS_X:      r_pos[0] <= $signed(i_cfg_data[31:0]);
                REG_POS_Y:      r_pos[1] <= $signed(i_cfg_data[31:0]);
                REG_POS_Z:      r_pos[2] <= $signed(i_cfg_data[31:0]);
                REG_HALF_SIZES: r_half   <= i_cfg_data[59:0];
                REG_RADIUS:     r_radius <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NP-2:0], i_valid};
        end
    end

    sbsd_xform u_xform (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_qx     (i_qx),
        .i_qy     (i_qy),
        .i_qz     (i_qz),
        .i_rot    (r_rot),
        .i_pos    (r_pos),
        .i_half   (r_half),
        .i_radius (r_radius),
        .o_meta   (x_meta),
        .o_c      (x_c),
        .o_sum    (x_sum)
    );

    sbsd_sqrt #(.STEPS(SQRT_STEPS)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_meta (x_meta),
        .i_c    (x_c),
        .i_sum  (x_sum),
        .o_meta (s_meta),
        .o_c    (s_c),
        .o_len  (s_len)
    );

    sbsd_div #(.STEPS(DIV_STEPS)) u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_meta (s_meta),
        .i_c    (s_c),
        .i_len  (s_len),
        .o_meta (d_meta),
        .o_len  (d_len),
        .o_q    (d_q)
    );

    sbsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (r_vld[NP-1]),
        .i_ready  (i_ready),
        .i_rot    (r_rot),
        .i_radius (r_radius),
        .i_meta   (d_meta),
        .i_len    (d_len),
        .i_q      (d_q),
        .o_room   (en),
        .o_valid  (o_valid),
        .o_res    (res)
    );

    assign o_distance   = res.distance;
    assign o_grad_x     = res.gx;
    assign o_grad_y     = res.gy;
    assign o_grad_z     = res.gz;
    assign o_is_inside  = res.in_box;
    assign o_degenerate = res.degen;

    a_degen_zero_grad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_grad_x == '0 && o_grad_y == '0 && o_grad_z == '0))
        else $error("degenerate word carries a nonzero gradient");

    a_degen_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_degenerate && o_is_inside))
        else $error("inside word flagged degenerate");

    a_inside_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_inside) |-> (o_distance[31] || o_distance == '0))
        else $error("inside word with positive distance");

endmodule

@@ verif/sbsd_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// sbsd_checker
// Watches the configuration, query and result channels of the swept box
// distance unit. Keeps its own copy of the registers, predicts the signed
// distance, gradient and flags of every accepted query word and compares
// each accepted result word against the oldest prediction.
// ============================================================================
module sbsd_checker import sbsd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic signed [31:0]    i_qx,
    input  logic signed [31:0]    i_qy,
    input  logic signed [31:0]    i_qz,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic signed [31:0]    i_distance,
    input  logic signed [17:0]    i_grad_x,
    input  logic signed [17:0]    i_grad_y,
    input  logic signed [17:0]    i_grad_z,
    input  logic                  i_is_inside,
    input  logic                  i_degenerate,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [53:0] rot_q [3];
    longint      center_q [3];
    logic [59:0] half_q;
    logic [30:0] radius_q;
    t_res        sdf_expected [$];

    function automatic longint rot_entry(input int i, input int j);
        logic signed [17:0] e;
        e = rot_q[i][18*j +: 18];
        return longint'(e);
    endfunction

    function automatic logic [63:0] wide_isqrt(input logic [67:0] val);
        logic [63:0] res;
        logic [71:0] rem;
        logic [71:0] trial;
        res = '0;
        rem = '0;
        for (int k = 33; k >= 0; k--) begin
            rem   = (rem << 2) | 72'(val[2*k +: 2]);
            trial = (72'(res) << 2) | 72'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                res = (res << 1) | 64'd1;
            end else begin
                res = res << 1;
            end
        end
        return res;
    endfunction

    function automatic t_res predict_sdf(input logic signed [31:0] qx,
                                         input logic signed [31:0] qy,
                                         input logic signed [31:0] qz);
        longint      d [3];
        longint      p [3];
        longint      bx [3];
        longint      dab [3];
        longint      cl [3];
        longint      del [3];
        longint      u [3];
        logic [63:0] mag [3];
        logic [63:0] c [3];
        logic [63:0] len;
        logic [67:0] ssum;
        longint      acc;
        longint      v;
        int          s;
        int          side;
        bit          ins;
        t_res        r;
        d[0] = longint'(qx) - center_q[0];
        d[1] = longint'(qy) - center_q[1];
        d[2] = longint'(qz) - center_q[2];
        for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int i = 0; i < 3; i++) acc += rot_entry(i, j) * d[i];
            p[j]   = (acc + 32768) >>> 16;
            bx[j]  = longint'(half_q[20*j +: 20]) - longint'(radius_q);
            dab[j] = (p[j] < 0 ? -p[j] : p[j]) - bx[j];
            cl[j]  = p[j];
        end
        side = 0;
        for (int j = 1; j < 3; j++) if (dab[j] > dab[side]) side = j;
        ins = dab[side] < 0;
        if (ins) begin
            cl[side] = p[side] > 0 ? bx[side] : -bx[side];
        end else begin
            for (int j = 0; j < 3; j++) begin
                if (cl[j] < -bx[j]) cl[j] = -bx[j];
                if (cl[j] > bx[j]) cl[j] = bx[j];
            end
        end
        for (int j = 0; j < 3; j++) begin
            del[j] = p[j] - cl[j];
            mag[j] = del[j] < 0 ? -del[j] : del[j];
        end
        s = 0;
        while ((mag[0] >> s) >= 64'h1_0000_0000 || (mag[1] >> s) >= 64'h1_0000_0000 ||
               (mag[2] >> s) >= 64'h1_0000_0000) s++;
        ssum = '0;
        for (int j = 0; j < 3; j++) begin
            c[j] = mag[j] >> s;
            ssum = ssum + 68'(c[j]) * 68'(c[j]);
        end
        len = wide_isqrt(ssum);
        r.in_box = ins;
        r.degen  = (len == 0);
        if (s > 0) begin
            r.distance = ins ? DIST_MIN : DIST_MAX;
        end else begin
            v = (ins ? -longint'(len) : longint'(len)) - longint'(radius_q);
            if (v < longint'(DIST_MIN)) v = longint'(DIST_MIN);
            if (v > longint'(DIST_MAX)) v = longint'(DIST_MAX);
            r.distance = v[31:0];
        end
        r.gx = '0;
        r.gy = '0;
        r.gz = '0;
        if (len != 0) begin
            for (int j = 0; j < 3; j++) begin
                v = longint'(((c[j] << 16) + (len >> 1)) / len);
                if (del[j] < 0) v = -v;
                u[j] = ins ? -v : v;
            end
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) acc += rot_entry(i, j) * u[j];
                v = (acc + 32768) >>> 16;
                if (v < -131072) v = -131072;
                if (v > 131071) v = 131071;
                if (i == 0) r.gx = v[17:0];
                else if (i == 1) r.gy = v[17:0];
                else r.gz = v[17:0];
            end
        end
        return r;
    endfunction

    assign o_pending = sdf_expected.size();

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                rot_q[i]    <= '0;
                center_q[i] <= 0;
            end
            half_q       <= '0;
            radius_q     <= '0;
            o_fail_count <= 0;
            sdf_expected.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROT_ROW0:   rot_q[0]    <= i_cfg_data[53:0];
                    REG_ROT_ROW1:   rot_q[1]    <= i_cfg_data[53:0];
                    REG_ROT_ROW2:   rot_q[2]    <= i_cfg_data[53:0];
                    REG_POS_X:      center_q[0] <= longint'($signed(i_cfg_data[31:0]));
                    REG_POS_Y:      center_q[1] <= longint'($signed(i_cfg_data[31:0]));
                    REG_POS_Z:      center_q[2] <= longint'($signed(i_cfg_data[31:0]));
                    REG_HALF_SIZES: half_q      <= i_cfg_data[59:0];
                    REG_RADIUS:     radius_q    <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) sdf_expected.push_back(predict_sdf(i_qx, i_qy, i_qz));
            if (i_out_valid && i_out_ready) begin
                if (sdf_expected.size() == 0) begin
                    $error("result word with no query pending");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = sdf_expected.pop_front();
                    if (want.distance !== i_distance ||
                        want.gx !== i_grad_x || want.gy !== i_grad_y ||
                        want.gz !== i_grad_z || want.in_box !== i_is_inside ||
                        want.degen !== i_degenerate)
                        o_fail_count <= o_fail_count + 1;
                    if (want.distance !== i_distance)
                        $error("distance: expected %0d actual %0d", want.distance, i_distance);
                    if (want.gx !== i_grad_x)
                        $error("grad_x: expected %0d actual %0d", want.gx, i_grad_x);
                    if (want.gy !== i_grad_y)
                        $error("grad_y: expected %0d actual %0d", want.gy, i_grad_y);
                    if (want.gz !== i_grad_z)
                        $error("grad_z: expected %0d actual %0d", want.gz, i_grad_z);
                    if (want.in_box !== i_is_inside)
                        $error("is_inside: expected %0d actual %0d", want.in_box, i_is_inside);
                    if (want.degen !== i_degenerate)
                        $error("degenerate: expected %0d actual %0d", want.degen, i_degenerate);
                end
            end
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb
// Drives the swept box distance unit through several register settings
// (reset values, identity and rotated frames, extreme rotations, radius
// above two half sizes, far centers) with directed and random query words,
// bursty input and a stalling result side. A checker module predicts and
// compares every result word.
// ============================================================================
module tb import sbsd_pkg::*;;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ONE = 65536;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  q_valid;
    logic                  q_ready;
    logic signed [31:0]    qx;
    logic signed [31:0]    qy;
    logic signed [31:0]    qz;
    logic                  r_valid;
    logic                  r_ready;
    logic signed [31:0]    distance;
    logic signed [17:0]    grad_x;
    logic signed [17:0]    grad_y;
    logic signed [17:0]    grad_z;
    logic                  is_inside;
    logic                  degenerate;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles;
    int                    burst_left;
    int                    stall_mode;
    int                    mode_left;

    swept_box_signed_distance_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(q_valid), .o_ready(q_ready),
        .i_qx(qx), .i_qy(qy), .i_qz(qz),
        .o_valid(r_valid), .i_ready(r_ready),
        .o_distance(distance), .o_grad_x(grad_x), .o_grad_y(grad_y),
        .o_grad_z(grad_z), .o_is_inside(is_inside), .o_degenerate(degenerate)
    );

    sbsd_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(q_valid), .i_in_ready(q_ready),
        .i_qx(qx), .i_qy(qy), .i_qz(qz),
        .i_out_valid(r_valid), .i_out_ready(r_ready),
        .i_distance(distance), .i_grad_x(grad_x), .i_grad_y(grad_y),
        .i_grad_z(grad_z), .i_is_inside(is_inside), .i_degenerate(degenerate),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [53:0] pack_row(input int a, input int b, input int c);
        return {c[17:0], b[17:0], a[17:0]};
    endfunction

    function automatic logic [59:0] pack_half(input int x, input int y, input int z);
        return {z[19:0], y[19:0], x[19:0]};
    endfunction

    function automatic logic [53:0] rand_row();
        return {18'($urandom), 18'($urandom), 18'($urandom)};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_box(input logic [53:0] r0, input logic [53:0] r1, input logic [53:0] r2,
                            input int px, input int py, input int pz,
                            input logic [59:0] hs, input logic [30:0] rad);
        q_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_ROT_ROW0, 60'(r0));
        write_reg(REG_ROT_ROW1, 60'(r1));
        write_reg(REG_ROT_ROW2, 60'(r2));
        write_reg(REG_POS_X, 60'(unsigned'(px)));
        write_reg(REG_POS_Y, 60'(unsigned'(py)));
        write_reg(REG_POS_Z, 60'(unsigned'(pz)));
        write_reg(REG_HALF_SIZES, hs);
        write_reg(REG_RADIUS, 60'(rad));
        burst_left = 0;
    endtask

    task automatic send_query(input int x, input int y, input int z);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                q_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        q_valid <= 1'b1;
        qx <= x;
        qy <= y;
        qz <= z;
        @(posedge clk);
        while (!q_ready) @(posedge clk);
    endtask

    function automatic int near_coord();
        return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
    endfunction

    task automatic random_queries(input int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) send_query(near_coord(), near_coord(), near_coord());
            else if (pick < 8) send_query($urandom, $urandom, $urandom);
            else send_query(near_coord(), $urandom, near_coord());
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            r_ready    <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: r_ready <= 1'b1;
                1: r_ready <= $urandom_range(0, 1);
                default: r_ready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (q_valid && q_ready) || (r_valid && r_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        q_valid     = 1'b0;
        qx          = '0;
        qy          = '0;
        qz          = '0;
        burst_left  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: everything degenerate
        send_query(0, 0, 0);
        send_query(32'h7fffffff, 32'h80000000, ONE);

        // identity frame, half sizes one, two and three, no rounding
        load_box(pack_row(ONE, 0, 0), pack_row(0, ONE, 0), pack_row(0, 0, ONE),
                 0, 0, 0, pack_half(ONE, 2 * ONE, 3 * ONE), 31'd0);
        send_query(0, 0, 0);
        send_query(ONE, 0, 0);
        send_query(ONE / 2, ONE / 2, ONE / 2);
        send_query(-ONE / 2, -3 * ONE / 2, 0);
        send_query(3 * ONE, 5 * ONE, -7 * ONE);
        send_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_query(32'h80000000, 32'h80000000, 32'h80000000);
        send_query(32'h80000000, 0, 32'h7fffffff);
        send_query(2 * ONE, 0, 0);
        send_query(0, 0, -ONE / 4);

        // equal half sizes: face ties inside
        load_box(pack_row(ONE, 0, 0), pack_row(0, ONE, 0), pack_row(0, 0, ONE),
                 0, 0, 0, pack_half(ONE, ONE, ONE), 31'd0);
        send_query(0, 0, 0);
        send_query(ONE / 2, ONE / 2, ONE / 2);
        send_query(-ONE / 2, ONE / 2, ONE / 4);
        send_query(ONE / 4, -ONE / 2, -ONE / 2);
        random_queries(150);

        // quarter turn about z, rounded, offset center
        load_box(pack_row(0, -ONE, 0), pack_row(ONE, 0, 0), pack_row(0, 0, ONE),
                 ONE, -2 * ONE, ONE / 3, pack_half(2 * ONE, ONE, ONE / 2), 31'(ONE / 4));
        send_query(ONE, -2 * ONE, ONE / 3);
        random_queries(170);

        // radius above the x and y half sizes
        load_box(pack_row(ONE, 0, 0), pack_row(0, ONE, 0), pack_row(0, 0, ONE),
                 0, 0, 0, pack_half(ONE / 2, ONE, 20'hfffff), 31'(3 * ONE));
        send_query(0, 0, 0);
        random_queries(160);

        // extreme rotation entries and far centers
        load_box(pack_row(131071, 131071, 131071), pack_row(-131072, -131072, -131072),
                 pack_row(131071, -131072, 131071), 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, pack_half(20'hfffff, 20'hfffff, 20'hfffff), 31'h7fffffff);
        send_query(32'h80000000, 32'h7fffffff, 32'h80000000);
        send_query(0, 0, 0);
        random_queries(140);

        // random frames
        for (int ph = 0; ph < 3; ph++) begin
            load_box(rand_row(), rand_row(), rand_row(), near_coord(), near_coord(),
                     near_coord(), {20'($urandom_range(0, 4 * ONE)),
                     20'($urandom_range(0, 4 * ONE)), 20'($urandom)},
                     31'($urandom_range(0, ONE)));
            random_queries(130);
        end

        q_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sbsd_pkg.sv
rtl/sbsd_xform.sv
rtl/sbsd_sqrt.sv
rtl/sbsd_div.sv
rtl/sbsd_back.sv
rtl/swept_box_signed_distance_unit.sv
verif/sbsd_checker.sv
verif/tb.sv
